// ----- hw/rtl/calendar_date_shift_by_days_defines.svh -----
// Assertion macros shared by the date shift block.
`ifndef CALENDAR_DATE_SHIFT_BY_DAYS_DEFINES_SVH
`define CALENDAR_DATE_SHIFT_BY_DAYS_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define CDS_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define CDS_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- hw/rtl/cds_pkg.sv -----
// Shared widths, codes, types and calendar functions of the date shift block.
package cds_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int STATUS_W = 2;

   localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
   localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
   localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
   localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;
   localparam logic [DAY_W-1:0]   DEC_DAYS    = 5'd31;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_DATE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

   // The year modulo 400 is found once per beat as y - 400 * floor(y * RECIP / 2^SHIFT).
   localparam int R400_W      = 9;
   localparam int Q_W         = 6;
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 21;
   localparam int PROD_W      = RECIP_SHIFT + Q_W;
   localparam logic [RECIP_W-1:0] RECIP_400 = 13'd5243;
   localparam logic [R400_W-1:0]  CYCLE_400 = 9'd400;
   localparam logic [R400_W-1:0]  R400_LAST = 9'd399;

   typedef struct packed {
      logic load;
      logic mul;
      logic rem;
      logic check;
      logic walk;
      logic emit;
   } cds_cmd_type;

   typedef struct packed {
      logic check_fail;
      logic walk_done;
   } cds_sts_type;

   function automatic logic is_leap(input logic [1:0] y_low, input logic [R400_W-1:0] r400);
      logic century;
      century = (r400 == 9'd100) || (r400 == 9'd200) || (r400 == 9'd300);
      return ((y_low == 2'd0) && !century) || (r400 == 9'd0);
   endfunction

   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
      logic [DAY_W-1:0] n;
      case (month)
         4'd2:    n = leap ? 5'd29 : 5'd28;
         4'd4:    n = 5'd30;
         4'd6:    n = 5'd30;
         4'd9:    n = 5'd30;
         4'd11:   n = 5'd30;
         default: n = 5'd31;
      endcase
      return n;
   endfunction

endpackage

// ----- hw/rtl/cds_dp.sv -----
// Datapath of the date shift block: working date, day budget and result register.
`include "calendar_date_shift_by_days_defines.svh"

module cds_dp #(
   parameter int SHIFT_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cds_pkg::cds_cmd_type          cmd,
   output cds_pkg::cds_sts_type          sts,
   input  logic                          req_opcode,
   input  logic [cds_pkg::YEAR_W-1:0]    req_start_year,
   input  logic [cds_pkg::MONTH_W-1:0]   req_start_month,
   input  logic [cds_pkg::DAY_W-1:0]     req_start_day,
   input  logic [SHIFT_WIDTH-1:0]        req_shift_days,
   output logic [cds_pkg::YEAR_W-1:0]    rsp_result_year,
   output logic [cds_pkg::MONTH_W-1:0]   rsp_result_month,
   output logic [cds_pkg::DAY_W-1:0]     rsp_result_day,
   output logic [cds_pkg::STATUS_W-1:0]  rsp_status
);

   logic                           dir_ff, dir_in;
   logic [cds_pkg::YEAR_W-1:0]     y0_ff, y0_in, y_ff, y_in;
   logic [cds_pkg::MONTH_W-1:0]    m0_ff, m0_in, m_ff, m_in;
   logic [cds_pkg::DAY_W-1:0]      d0_ff, d0_in, d_ff, d_in;
   logic [SHIFT_WIDTH-1:0]         sub_ff, sub_in;
   logic [cds_pkg::Q_W-1:0]        q_ff, q_in;
   logic [cds_pkg::R400_W-1:0]     r400_ff, r400_in;
   logic [cds_pkg::STATUS_W-1:0]   st_ff, st_in;
   logic [cds_pkg::YEAR_W-1:0]     out_y_ff, out_y_in;
   logic [cds_pkg::MONTH_W-1:0]    out_m_ff, out_m_in;
   logic [cds_pkg::DAY_W-1:0]      out_d_ff, out_d_in;
   logic [cds_pkg::STATUS_W-1:0]   out_st_ff, out_st_in;

   logic [cds_pkg::PROD_W-1:0]     prod;
   logic [cds_pkg::YEAR_W-1:0]     rem_full;
   logic                           leap_cur;
   logic [cds_pkg::DAY_W-1:0]      ml_cur, ml_prev, gap;
   logic [cds_pkg::MONTH_W-1:0]    m_prev;
   logic [SHIFT_WIDTH-1:0]         gap_ext, step_ext, d_ext;
   logic                           date_bad;
   logic [cds_pkg::STATUS_W-1:0]   check_st;
   logic                           fits;
   logic                           walk_done;

   always_comb begin
      prod     = cds_pkg::PROD_W'(y0_ff) * cds_pkg::PROD_W'(cds_pkg::RECIP_400);
      rem_full = y0_ff - (cds_pkg::YEAR_W'(q_ff) * cds_pkg::YEAR_W'(cds_pkg::CYCLE_400));
      leap_cur = cds_pkg::is_leap(y_ff[1:0], r400_ff);
      ml_cur   = cds_pkg::month_length(m_ff, leap_cur);
      m_prev   = m_ff - cds_pkg::MONTH_FIRST;
      ml_prev  = cds_pkg::month_length(m_prev, leap_cur);
      gap      = ml_cur - d_ff;
      gap_ext  = {{(SHIFT_WIDTH-cds_pkg::DAY_W){1'b0}}, gap};
      step_ext = {{(SHIFT_WIDTH-cds_pkg::DAY_W-1){1'b0}},
                  ({1'b0, gap} + {{cds_pkg::DAY_W{1'b0}}, 1'b1})};
      d_ext    = {{(SHIFT_WIDTH-cds_pkg::DAY_W){1'b0}}, d_ff};

      date_bad = (m_ff < cds_pkg::MONTH_FIRST) || (m_ff > cds_pkg::MONTH_LAST) ||
                 (d_ff == '0) || (d_ff > ml_cur);
      if (date_bad) begin
         check_st = cds_pkg::ST_BAD_DATE;
      end else if (y_ff > cds_pkg::YEAR_MAX) begin
         check_st = cds_pkg::ST_RANGE;
      end else begin
         check_st = cds_pkg::ST_OK;
      end

      fits = dir_ff ? (sub_ff <= gap_ext) : (d_ext > sub_ff);
      walk_done = (sub_ff == '0) || fits ||
                  (dir_ff && (m_ff == cds_pkg::MONTH_LAST) && (y_ff == cds_pkg::YEAR_MAX)) ||
                  (!dir_ff && (m_ff == cds_pkg::MONTH_FIRST) && (y_ff == '0));

      dir_in    = dir_ff;
      y0_in     = y0_ff;
      m0_in     = m0_ff;
      d0_in     = d0_ff;
      y_in      = y_ff;
      m_in      = m_ff;
      d_in      = d_ff;
      sub_in    = sub_ff;
      q_in      = q_ff;
      r400_in   = r400_ff;
      st_in     = st_ff;
      out_y_in  = out_y_ff;
      out_m_in  = out_m_ff;
      out_d_in  = out_d_ff;
      out_st_in = out_st_ff;

      if (cmd.load) begin
         dir_in = req_opcode;
         y0_in  = req_start_year;
         m0_in  = req_start_month;
         d0_in  = req_start_day;
         y_in   = req_start_year;
         m_in   = req_start_month;
         d_in   = req_start_day;
         sub_in = req_shift_days;
      end
      if (cmd.mul) begin
         q_in = prod[cds_pkg::PROD_W-1 -: cds_pkg::Q_W];
      end
      if (cmd.rem) begin
         r400_in = rem_full[cds_pkg::R400_W-1:0];
      end
      if (cmd.check) begin
         st_in = check_st;
      end
      if (cmd.walk && (sub_ff != '0)) begin
         if (fits) begin
            d_in   = dir_ff ? (d_ff + sub_ff[cds_pkg::DAY_W-1:0])
                            : (d_ff - sub_ff[cds_pkg::DAY_W-1:0]);
            sub_in = '0;
         end else if (dir_ff) begin
            sub_in = sub_ff - step_ext;
            d_in   = cds_pkg::DAY_FIRST;
            if (m_ff == cds_pkg::MONTH_LAST) begin
               if (y_ff == cds_pkg::YEAR_MAX) begin
                  st_in = cds_pkg::ST_RANGE;
               end else begin
                  m_in    = cds_pkg::MONTH_FIRST;
                  y_in    = y_ff + 1'b1;
                  r400_in = (r400_ff == cds_pkg::R400_LAST) ? '0 : r400_ff + 1'b1;
               end
            end else begin
               m_in = m_ff + 1'b1;
            end
         end else begin
            sub_in = sub_ff - d_ext;
            if (m_ff == cds_pkg::MONTH_FIRST) begin
               if (y_ff == '0) begin
                  st_in = cds_pkg::ST_RANGE;
               end else begin
                  m_in    = cds_pkg::MONTH_LAST;
                  y_in    = y_ff - 1'b1;
                  r400_in = (r400_ff == '0) ? cds_pkg::R400_LAST : r400_ff - 1'b1;
                  d_in    = cds_pkg::DEC_DAYS;
               end
            end else begin
               m_in = m_prev;
               d_in = ml_prev;
            end
         end
      end
      if (cmd.emit) begin
         out_st_in = st_ff;
         if (st_ff != cds_pkg::ST_OK) begin
            out_y_in = y0_ff;
            out_m_in = m0_ff;
            out_d_in = d0_ff;
         end else begin
            out_y_in = y_ff;
            out_m_in = m_ff;
            out_d_in = d_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      dir_ff    <= dir_in;
      y0_ff     <= y0_in;
      m0_ff     <= m0_in;
      d0_ff     <= d0_in;
      y_ff      <= y_in;
      m_ff      <= m_in;
      d_ff      <= d_in;
      sub_ff    <= sub_in;
      q_ff      <= q_in;
      r400_ff   <= r400_in;
      st_ff     <= st_in;
      out_y_ff  <= out_y_in;
      out_m_ff  <= out_m_in;
      out_d_ff  <= out_d_in;
      out_st_ff <= out_st_in;
   end

   assign sts.check_fail = (check_st != cds_pkg::ST_OK);
   assign sts.walk_done  = walk_done;

   assign rsp_result_year  = out_y_ff;
   assign rsp_result_month = out_m_ff;
   assign rsp_result_day   = out_d_ff;
   assign rsp_status       = out_st_ff;

   `CDS_ASSERT_NOW(a_walk_month_legal, cmd.walk,
      (m_ff >= cds_pkg::MONTH_FIRST) && (m_ff <= cds_pkg::MONTH_LAST),
      "Month left 1..12 during the walk.")

endmodule

// ----- hw/rtl/cds_ctrl.sv -----
// Controller of the date shift block: sequences setup, the month walk and the result beat.
`include "calendar_date_shift_by_days_defines.svh"

module cds_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cds_pkg::cds_cmd_type  cmd,
   input  cds_pkg::cds_sts_type  sts
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MUL    = 3'd1;
   localparam logic [2:0] S_REM    = 3'd2;
   localparam logic [2:0] S_CHECK  = 3'd3;
   localparam logic [2:0] S_WALK   = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   always_comb begin
      slot_free    = !rsp_valid_ff || rsp_ready;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_REM;
         end
         S_REM: begin
            cmd.rem  = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = sts.check_fail ? S_FINISH : S_WALK;
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (sts.walk_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `CDS_ASSERT_NOW(a_emit_slot_free, cmd.emit, !rsp_valid_ff || rsp_ready,
      "Result register overwritten while its beat was pending.")
   `CDS_ASSERT_NEXT(a_bad_date_skips_walk, (state_ff == S_CHECK) && sts.check_fail,
      state_ff == S_FINISH, "Rejected date entered the month walk.")
   `CDS_ASSERT_NEXT(a_load_starts_setup, cmd.load, state_ff == S_MUL,
      "Accepted beat did not start the setup sequence.")

endmodule

// ----- hw/rtl/calendar_date_shift_by_days.sv -----
// Top level of the Gregorian date shift block.
// Moves a date forward (opcode 1) or backward (opcode 0) by req_shift_days days, walking one
// calendar month per clock cycle. An item first runs its setup steps (year modulo 400 and date
// check), then walks the months until the remaining days fit or the year range ends, then loads
// the result register once it is free; a 16-bit count crosses up to roughly 2160 months.
// A bad month or day returns status 1 and a year outside 0..9999 returns status 2, each with
// the start date echoed. The next request is taken once the result sits in the output
// register, while that result still waits for its beat.
module calendar_date_shift_by_days #(
   parameter int SHIFT_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [cds_pkg::YEAR_W-1:0]    req_start_year,
   input  logic [cds_pkg::MONTH_W-1:0]   req_start_month,
   input  logic [cds_pkg::DAY_W-1:0]     req_start_day,
   input  logic [SHIFT_WIDTH-1:0]        req_shift_days,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cds_pkg::YEAR_W-1:0]    rsp_result_year,
   output logic [cds_pkg::MONTH_W-1:0]   rsp_result_month,
   output logic [cds_pkg::DAY_W-1:0]     rsp_result_day,
   output logic [cds_pkg::STATUS_W-1:0]  rsp_status
);

   cds_pkg::cds_cmd_type cmd;
   cds_pkg::cds_sts_type sts;

   cds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   cds_dp #(
      .SHIFT_WIDTH (SHIFT_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_opcode       (req_opcode),
      .req_start_year   (req_start_year),
      .req_start_month  (req_start_month),
      .req_start_day    (req_start_day),
      .req_shift_days   (req_shift_days),
      .rsp_result_year  (rsp_result_year),
      .rsp_result_month (rsp_result_month),
      .rsp_result_day   (rsp_result_day),
      .rsp_status       (rsp_status)
   );

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the Gregorian date shift block.
`timescale 1ns / 1ps

module testbench;

   localparam int  SHIFT_W     = 16;
   localparam int  MONTHS      = 12;
   localparam int  YEAR_TOP    = 9999;
   localparam int  YEAR_FIELD_TOP = 16383;
   localparam int  SHIFT_TOP   = 65535;
   localparam int  REPORT_MAX  = 10;
   localparam logic OP_SUB     = 1'b0;
   localparam logic OP_ADD     = 1'b1;

   typedef struct packed {
      logic                         op;
      logic [cds_pkg::YEAR_W-1:0]   year;
      logic [cds_pkg::MONTH_W-1:0]  month;
      logic [cds_pkg::DAY_W-1:0]    day;
      logic [SHIFT_W-1:0]           shift;
   } date_req_type;

   typedef struct packed {
      logic [cds_pkg::YEAR_W-1:0]   year;
      logic [cds_pkg::MONTH_W-1:0]  month;
      logic [cds_pkg::DAY_W-1:0]    day;
      logic [cds_pkg::STATUS_W-1:0] status;
   } date_rsp_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_opcode = 1'b0;
   logic [cds_pkg::YEAR_W-1:0]    req_start_year = '0;
   logic [cds_pkg::MONTH_W-1:0]   req_start_month = '0;
   logic [cds_pkg::DAY_W-1:0]     req_start_day = '0;
   logic [SHIFT_W-1:0]            req_shift_days = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [cds_pkg::YEAR_W-1:0]    rsp_result_year;
   logic [cds_pkg::MONTH_W-1:0]   rsp_result_month;
   logic [cds_pkg::DAY_W-1:0]     rsp_result_day;
   logic [cds_pkg::STATUS_W-1:0]  rsp_status;

   date_rsp_type pending_dates[$];
   int        mismatch_count = 0;
   bit        req_gaps_on = 1'b1;
   bit        rsp_stalls_on = 1'b1;

   calendar_date_shift_by_days #(
      .SHIFT_WIDTH(SHIFT_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_start_year(req_start_year),
      .req_start_month(req_start_month),
      .req_start_day(req_start_day),
      .req_shift_days(req_shift_days),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result_year(rsp_result_year),
      .rsp_result_month(rsp_result_month),
      .rsp_result_day(rsp_result_day),
      .rsp_status(rsp_status)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic bit leap_year(input int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int days_in_month(input int m, input int y);
      case (m)
         2:       return leap_year(y) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default: return 31;
      endcase
   endfunction

   function automatic date_rsp_type shift_date(input date_req_type r);
      int y, m, d, left, ml;
      logic [cds_pkg::STATUS_W-1:0] st;
      date_rsp_type res;
      y = int'(r.year);
      m = int'(r.month);
      d = int'(r.day);
      left = int'(r.shift);
      st = cds_pkg::ST_OK;
      if (m < 1 || m > MONTHS || d < 1 || d > days_in_month(m, y)) begin
         st = cds_pkg::ST_BAD_DATE;
      end else if (y > YEAR_TOP) begin
         st = cds_pkg::ST_RANGE;
      end else if (r.op == OP_SUB) begin
         while (left > 0) begin
            if (d > left) begin
               d -= left;
               left = 0;
            end else begin
               left -= d;
               m--;
               if (m == 0) begin
                  m = MONTHS;
                  y--;
               end
               if (y < 0) begin
                  st = cds_pkg::ST_RANGE;
                  left = 0;
               end else begin
                  d = days_in_month(m, y);
               end
            end
         end
      end else begin
         while (left > 0) begin
            ml = days_in_month(m, y);
            if (d + left <= ml) begin
               d += left;
               left = 0;
            end else begin
               left -= ml - d + 1;
               m++;
               if (m > MONTHS) begin
                  m = 1;
                  y++;
               end
               if (y > YEAR_TOP) begin
                  st = cds_pkg::ST_RANGE;
                  left = 0;
               end else begin
                  d = 1;
               end
            end
         end
      end
      if (st != cds_pkg::ST_OK) begin
         res.year = r.year;
         res.month = r.month;
         res.day = r.day;
      end else begin
         res.year = cds_pkg::YEAR_W'(y);
         res.month = cds_pkg::MONTH_W'(m);
         res.day = cds_pkg::DAY_W'(d);
      end
      res.status = st;
      return res;
   endfunction

   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(30, 200);
   endfunction

   function automatic date_req_type make_req(input logic op, input int y, input int m,
                                             input int d, input int shift);
      date_req_type r;
      r.op = op;
      r.year = cds_pkg::YEAR_W'(y);
      r.month = cds_pkg::MONTH_W'(m);
      r.day = cds_pkg::DAY_W'(d);
      r.shift = SHIFT_W'(shift);
      return r;
   endfunction

   function automatic int pick_shift();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) return $urandom_range(0, 400);
      if (r < 17) return $urandom_range(0, 5000);
      if (r < 19) return $urandom_range(0, SHIFT_TOP);
      return ($urandom_range(0, 1) == 1) ? SHIFT_TOP : 0;
   endfunction

   function automatic date_req_type random_valid_req();
      int y, m, d;
      case ($urandom_range(0, 9))
         0:       y = $urandom_range(0, 3);
         1:       y = $urandom_range(YEAR_TOP - 3, YEAR_TOP);
         2:       y = 100 * $urandom_range(0, 99);
         default: y = $urandom_range(0, YEAR_TOP);
      endcase
      m = $urandom_range(1, MONTHS);
      if ($urandom_range(0, 3) == 0) begin
         d = days_in_month(m, y);
      end else begin
         d = $urandom_range(1, days_in_month(m, y));
      end
      return make_req(1'($urandom_range(0, 1)), y, m, d, pick_shift());
   endfunction

   task automatic send_shift(input date_req_type r);
      int gap;
      pending_dates.push_back(shift_date(r));
      req_valid <= 1'b1;
      req_opcode <= r.op;
      req_start_year <= r.year;
      req_start_month <= r.month;
      req_start_day <= r.day;
      req_shift_days <= r.shift;
      do @(posedge clock); while (!req_ready);
      gap = req_gaps_on ? pick_idle() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_all_results();
      while (pending_dates.size() != 0) @(posedge clock);
   endtask

   task automatic test_calendar_edges();
      send_shift(make_req(OP_ADD, 2024, 2, 29, 0));
      send_shift(make_req(OP_SUB, 2024, 2, 29, 0));
      send_shift(make_req(OP_ADD, YEAR_TOP, 12, 31, 0));
      send_shift(make_req(OP_ADD, 2023, 12, 31, 1));
      send_shift(make_req(OP_SUB, 2024, 3, 1, 1));
      send_shift(make_req(OP_ADD, 1900, 2, 28, 1));
      send_shift(make_req(OP_ADD, 2000, 2, 28, 1));
      send_shift(make_req(OP_ADD, 0, 1, 1, SHIFT_TOP));
      send_shift(make_req(OP_SUB, YEAR_TOP, 12, 31, SHIFT_TOP));
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_invalid_dates();
      send_shift(make_req(OP_ADD, 2020, 0, 10, 5));
      send_shift(make_req(OP_SUB, 2020, 15, 31, 5));
      send_shift(make_req(OP_ADD, 2020, 13, 1, 5));
      send_shift(make_req(OP_ADD, 2020, 6, 0, 5));
      send_shift(make_req(OP_SUB, 2020, 4, 31, 5));
      send_shift(make_req(OP_ADD, 1900, 2, 29, 5));
      send_shift(make_req(OP_ADD, 0, 2, 29, 5));
      send_shift(make_req(OP_ADD, 10000, 13, 1, 5));
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_year_range();
      send_shift(make_req(OP_SUB, 0, 1, 1, 1));
      send_shift(make_req(OP_ADD, YEAR_TOP, 12, 31, 1));
      send_shift(make_req(OP_ADD, 9900, 1, 1, SHIFT_TOP));
      send_shift(make_req(OP_SUB, 0, 2, 29, SHIFT_TOP));
      send_shift(make_req(OP_ADD, YEAR_FIELD_TOP, 12, 31, 3));
      send_shift(make_req(OP_SUB, 10000, 1, 1, 0));
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_random_dates();
      for (int i = 0; i < 200; i++) begin
         if (i == 60) begin
            req_gaps_on = 1'b0;
            rsp_stalls_on = 1'b0;
         end
         if (i == 100) begin
            req_gaps_on = 1'b1;
            rsp_stalls_on = 1'b1;
         end
         if (i == 130) begin
            req_valid <= 1'b0;
            @(posedge clock);
            wait_all_results();
         end
         send_shift(random_valid_req());
      end
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_random_fields();
      int shift;
      for (int i = 0; i < 70; i++) begin
         shift = ($urandom_range(0, 9) == 0) ? $urandom_range(0, SHIFT_TOP)
                                              : $urandom_range(0, 2000);
         send_shift(make_req(1'($urandom_range(0, 1)), $urandom_range(0, YEAR_FIELD_TOP),
                             $urandom_range(0, 15), $urandom_range(0, 31), shift));
      end
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int stall;
      rsp_ready <= 1'b1;
      forever begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(30, 80)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         stall = rsp_stalls_on ? pick_idle() : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      date_rsp_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.year = rsp_result_year;
         got.month = rsp_result_month;
         got.day = rsp_result_day;
         got.status = rsp_status;
         if (pending_dates.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
               $display("unexpected result beat: %0d-%0d-%0d status %0d",
                        got.year, got.month, got.day, got.status);
            end
         end else begin
            want = pending_dates.pop_front();
            if (got.year !== want.year || got.month !== want.month ||
                got.day !== want.day || got.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX) begin
                  $display("mismatch: expected %0d-%0d-%0d status %0d, got %0d-%0d-%0d status %0d",
                           want.year, want.month, want.day, want.status,
                           got.year, got.month, got.day, got.status);
               end
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_calendar_edges();
      test_invalid_dates();
      test_year_range();
      test_random_dates();
      test_random_fields();
      wait_all_results();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
